// ===== hw/rtl/cbf_pkg.sv =====
// Package for the counting Bloom filter: constants, types and command codes.
// Used by the channel interfaces and the top level.
`timescale 1ns / 1ps
package cbf_pkg;
  localparam int TableDepth   = 1048576;
  localparam int AddrWidth    = 20;
  localparam int CounterWidth = 16;
  localparam int MaxProbes    = 32;
  localparam int ProbeWidth   = 6;
  localparam int SizeWidth    = 21;

  localparam logic [CounterWidth-1:0] CntMax = {CounterWidth{1'b1}};

  localparam logic [1:0] CmdAdd  = 2'd0;
  localparam logic [1:0] CmdFind = 2'd1;
  localparam logic [1:0] CmdDel  = 2'd2;

  localparam logic RegTableSize  = 1'b0;
  localparam logic RegProbeCount = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] hash_first;
    logic [31:0] hash_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        status;
    logic [31:0] total_items;
    logic [31:0] distinct_items;
    logic [31:0] overflow_total;
    logic [31:0] underflow_total;
  } out_item_t;
endpackage

// ===== hw/rtl/cbf_in_if.sv =====
// Input channel interface for the counting Bloom filter.
// Depends on cbf_pkg.
`timescale 1ns / 1ps
interface cbf_in_if;
  import cbf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/cbf_out_if.sv =====
// Output channel interface for the counting Bloom filter.
// Depends on cbf_pkg.
`timescale 1ns / 1ps
interface cbf_out_if;
  import cbf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/counting_bloom_filter.sv =====
// Counting Bloom filter with double hashing over a 1M x 16 counter RAM.
// Two restoring modulo reductions (h mod m, g mod m) come first; each probe then
// steps through read, wait, evaluate and next. Add makes one pass of k probes;
// find and delete read until a zero counter; a delete that meets none then writes.
// One transaction at a time; the single-port counter RAM paces each probe.
// Reset: a clearing pass writes all 1048576 counters (one per cycle) before
// the first transaction is accepted; totals and registers reset at once.
`timescale 1ns / 1ps
module counting_bloom_filter (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [20:0]             cfg_data,
  cbf_in_if.sink                  in_ch,
  cbf_out_if.source               out_ch
);
  import cbf_pkg::*;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StModH  = 4'd2;
  localparam logic [3:0] StModG  = 4'd3;
  localparam logic [3:0] StRead  = 4'd4;
  localparam logic [3:0] StWait  = 4'd5;
  localparam logic [3:0] StEval  = 4'd6;
  localparam logic [3:0] StNext  = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  logic [3:0]  state;
  logic [20:0] table_size;
  logic [5:0]  probe_count;
  logic [20:0] m_eff;
  logic [5:0]  k_eff;
  logic [31:0] item_total, distinct_total, overflow_count, underflow_count;

  // Effective table size and probe count.
  assign m_eff = (table_size == 21'd0) ? 21'd1 :
                 (table_size > 21'(TableDepth)) ? 21'(TableDepth) : table_size;
  assign k_eff = (probe_count == 6'd0) ? 6'd1 :
                 (probe_count > 6'(MaxProbes)) ? 6'(MaxProbes) : probe_count;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size  <= 21'(TableDepth);
      probe_count <= 6'd23;
    end else if (cfg_we) begin
      if (cfg_index == RegTableSize) table_size <= cfg_data;
      else probe_count <= cfg_data[5:0];
    end
  end

  // Counter memory with a registered read port.
  logic [CounterWidth-1:0] mem [TableDepth];
  logic [AddrWidth-1:0]    mem_addr;
  logic                    mem_we;
  logic [CounterWidth-1:0] mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  logic [1:0]  cmd;
  logic [31:0] hq, gq;           // dividend shifted during restoring modulo
  logic [20:0] rem;              // partial remainder
  logic [5:0]  bitcnt;
  logic [20:0] hm, gm, addr;     // h mod m, g mod m, current probe address
  logic [5:0]  idx;
  logic        pass2;            // second pass of delete, or the add pass
  logic        absent, distinct, emptied;
  logic [15:0] value, minv;
  logic [AddrWidth:0] clr_cnt;
  out_item_t   out_q;
  logic        out_valid;

  logic [21:0] rem_sh;
  logic [21:0] step_sum;
  logic [CounterWidth:0] inc;
  assign rem_sh   = {rem, (state == StModH) ? hq[31] : gq[31]};
  assign step_sum = {1'b0, addr} + {1'b0, gm};
  assign inc      = {1'b0, mem_rdata} + 17'd1;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = addr[AddrWidth-1:0];
    if (state == StClear) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt[AddrWidth-1:0];
    end else if (state == StEval && pass2) begin
      if (cmd == CmdAdd) begin
        mem_we    = 1'b1;
        mem_wdata = (inc >= {1'b0, CntMax}) ? CntMax : inc[CounterWidth-1:0];
      end else if (mem_rdata != CntMax && mem_rdata != '0) begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata - 16'd1;
      end
    end
  end

  assign in_ch.ready    = (state == StIdle) && !out_valid;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_q;

  // Sequencer: modulo setup, probe passes and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      item_total <= '0;
      distinct_total <= '0;
      overflow_count <= '0;
      underflow_count <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        StClear: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AddrWidth+1)'(TableDepth - 1)) state <= StIdle;
        end
        StIdle: begin
          if (in_ch.valid && in_ch.ready) begin
            cmd <= in_ch.payload.command;
            hq <= in_ch.payload.hash_first;
            gq <= in_ch.payload.hash_second;
            rem <= '0; bitcnt <= '0; idx <= '0;
            absent <= 1'b0; distinct <= 1'b0; emptied <= 1'b0;
            value <= '0; minv <= '0;
            pass2 <= (in_ch.payload.command == CmdAdd);
            state <= StModH;
          end
        end
        StModH, StModG: begin
          // One restoring step of the remainder per cycle.
          if (rem_sh >= {1'b0, m_eff}) rem <= 21'(rem_sh - {1'b0, m_eff});
          else rem <= rem_sh[20:0];
          if (state == StModH) hq <= hq << 1; else gq <= gq << 1;
          bitcnt <= bitcnt + 6'd1;
          if (bitcnt == 6'd31) begin
            bitcnt <= '0;
            if (state == StModH) begin
              hm <= (rem_sh >= {1'b0, m_eff}) ? 21'(rem_sh - {1'b0, m_eff}) : rem_sh[20:0];
              addr <= (rem_sh >= {1'b0, m_eff}) ? 21'(rem_sh - {1'b0, m_eff}) : rem_sh[20:0];
              rem <= '0;
              state <= StModG;
            end else begin
              gm <= (rem_sh >= {1'b0, m_eff}) ? 21'(rem_sh - {1'b0, m_eff}) : rem_sh[20:0];
              state <= (cmd == CmdAdd || cmd == CmdFind || cmd == CmdDel) ? StRead : StOut;
            end
          end
        end
        StRead: state <= StWait;
        StWait: state <= StEval;
        StEval: begin
          state <= StNext;
          if (!pass2) begin
            if (mem_rdata == '0) absent <= 1'b1;
            if (idx == 6'd0 || mem_rdata < minv) minv <= mem_rdata;
          end else if (cmd == CmdAdd) begin
            if (inc >= {1'b0, CntMax}) begin
              overflow_count <= overflow_count + 32'd1;
              value <= value + 16'd1;
            end else if (inc == 17'd1) distinct <= 1'b1;
          end else begin
            if (mem_rdata == CntMax) begin
              underflow_count <= underflow_count + 32'd1;
              value <= value + 16'd1;
            end else if (mem_rdata == 16'd1) emptied <= 1'b1;
          end
        end
        StNext: begin
          addr <= (step_sum >= {1'b0, m_eff}) ? 21'(step_sum - {1'b0, m_eff}) : step_sum[20:0];
          idx <= idx + 6'd1;
          state <= StRead;
          if (!pass2 && absent) state <= StOut;
          else if (idx + 6'd1 == k_eff) begin
            idx <= '0;
            addr <= hm;
            if (!pass2 && cmd == CmdDel) pass2 <= 1'b1;
            else state <= StOut;
          end
        end
        StOut: begin
          if (!out_valid) begin
            out_q.status <= 1'b0;
            out_q.value <= '0;
            out_q.total_items <= item_total;
            out_q.distinct_items <= distinct_total;
            if (cmd == CmdAdd) begin
              out_q.value <= value;
              out_q.total_items <= item_total + 32'd1;
              item_total <= item_total + 32'd1;
              if (distinct) begin
                distinct_total <= distinct_total + 32'd1;
                out_q.distinct_items <= distinct_total + 32'd1;
              end
            end else if (cmd == CmdFind) begin
              out_q.value <= absent ? 16'd0 : minv;
            end else if (cmd == CmdDel) begin
              if (absent) out_q.status <= 1'b1;
              else begin
                out_q.value <= value;
                out_q.total_items <= item_total - 32'd1;
                item_total <= item_total - 32'd1;
                if (emptied) begin
                  distinct_total <= distinct_total - 32'd1;
                  out_q.distinct_items <= distinct_total - 32'd1;
                end
              end
            end
            out_q.overflow_total <= overflow_count;
            out_q.underflow_total <= underflow_count;
            out_valid <= 1'b1;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // The memory is never written outside the clearing pass or the write pass.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == StClear || (state == StEval && pass2)))
    else $error("counter write outside write pass");
  // The probe address stays below the table size.
  assert property (@(posedge clk) disable iff (rst)
    (state == StRead) |-> (addr < m_eff))
    else $error("probe address out of range");
  // A transaction is accepted only when no result is pending.
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == StModH && !out_valid))
    else $error("accept with pending result");
endmodule

// ===== tb/sv/tb_counting_bloom_filter.sv =====
// Self-checking testbench for the counting Bloom filter: directed and random
// add, find and delete transactions checked against a built-in predictor.
// Depends on cbf_pkg, cbf_in_if, cbf_out_if and counting_bloom_filter.
`timescale 1ns / 1ps

// Predicts filter results and holds the expected results in order.
class bloom_scoreboard;
  bit [15:0]           counters [cbf_pkg::TableDepth];
  bit [31:0]           item_total, distinct_total, overflow_count, underflow_count;
  bit [20:0]           size_reg;
  bit [5:0]            probes_reg;
  cbf_pkg::out_item_t  pending_results [$];
  int                  errors;
  int                  checked;

  function new();
    foreach (counters[i]) counters[i] = '0;
    item_total = 0;
    distinct_total = 0;
    overflow_count = 0;
    underflow_count = 0;
    size_reg = 21'd1048576;
    probes_reg = 6'd23;
    errors = 0;
    checked = 0;
  endfunction

  function void write_reg(logic idx, bit [20:0] data);
    if (idx == cbf_pkg::RegTableSize) size_reg = data;
    else probes_reg = data[5:0];
  endfunction

  // Computes the result of one accepted transaction and queues it.
  function void note(cbf_pkg::in_item_t it);
    longint unsigned    m, h, g;
    int unsigned        k, a;
    bit [31:0]          nv;
    bit [31:0]          val;
    bit [15:0]          minv;
    bit                 flag, present;
    cbf_pkg::out_item_t r;
    m = size_reg;
    if (m == 0) m = 1;
    if (m > cbf_pkg::TableDepth) m = cbf_pkg::TableDepth;
    k = probes_reg;
    if (k == 0) k = 1;
    if (k > cbf_pkg::MaxProbes) k = cbf_pkg::MaxProbes;
    h = it.hash_first;
    g = it.hash_second;
    val = 0;
    flag = 0;
    r.status = 0;
    case (it.command)
      cbf_pkg::CmdAdd: begin
        for (int i = 0; i < k; i++) begin
          a = (h + i * g) % m;
          nv = counters[a] + 1;
          if (nv >= cbf_pkg::CntMax) begin
            counters[a] = cbf_pkg::CntMax;
            overflow_count++;
            val++;
          end else begin
            counters[a] = nv[15:0];
            if (nv == 1) flag = 1;
          end
        end
        item_total++;
        if (flag) distinct_total++;
      end
      cbf_pkg::CmdFind: begin
        minv = 0;
        for (int i = 0; i < k; i++) begin
          a = (h + i * g) % m;
          if (counters[a] == 0) begin
            minv = 0;
            break;
          end
          if (i == 0 || counters[a] < minv) minv = counters[a];
        end
        val = minv;
      end
      cbf_pkg::CmdDel: begin
        present = 1;
        for (int i = 0; i < k; i++)
          if (counters[(h + i * g) % m] == 0) present = 0;
        if (!present) begin
          r.status = 1;
        end else begin
          for (int i = 0; i < k; i++) begin
            a = (h + i * g) % m;
            if (counters[a] == cbf_pkg::CntMax) begin
              underflow_count++;
              val++;
            end else if (counters[a] != 0) begin
              counters[a]--;
              if (counters[a] == 0) flag = 1;
            end
          end
          item_total--;
          if (flag) distinct_total--;
        end
      end
      default: ;
    endcase
    r.value = val[15:0];
    r.total_items = item_total;
    r.distinct_items = distinct_total;
    r.overflow_total = overflow_count;
    r.underflow_total = underflow_count;
    pending_results.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  // Compares one accepted result with the oldest expectation.
  task check(cbf_pkg::out_item_t got);
    cbf_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report("unexpected result", 0, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.value !== want.value) report("value", got.value, want.value);
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.total_items !== want.total_items)
      report("total_items", got.total_items, want.total_items);
    if (got.distinct_items !== want.distinct_items)
      report("distinct_items", got.distinct_items, want.distinct_items);
    if (got.overflow_total !== want.overflow_total)
      report("overflow_total", got.overflow_total, want.overflow_total);
    if (got.underflow_total !== want.underflow_total)
      report("underflow_total", got.underflow_total, want.underflow_total);
    checked++;
  endtask
endclass

module tb_counting_bloom_filter;
  import cbf_pkg::*;

  localparam int CycleLimit = 12000000;
  localparam int SettleCycles = 300;
  // Command code with no operation behind it.
  localparam logic [1:0] CmdUnused = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [20:0] cfg_data;
  logic        no_idle;
  int          stall_left;
  int          cycles;
  int          sent;
  bit [63:0]   key_pool [$];

  bloom_scoreboard sb;

  cbf_in_if  in_ch ();
  cbf_out_if out_ch ();

  counting_bloom_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[counting_bloom_filter] ERROR");
      $finish;
    end
  end

  // Result side: check each transaction and stall ready in random bursts.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check(out_ch.payload);
    if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      stall_left <= $urandom_range(7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Drives one transaction and waits for its acceptance, then maybe idles.
  task send(logic [1:0] cmd, logic [31:0] h, logic [31:0] g);
    in_item_t it;
    it.command = cmd;
    it.hash_first = h;
    it.hash_second = g;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(it);
    sent++;
    if (cmd == CmdAdd) begin
      key_pool.push_back({h, g});
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
    if (!no_idle && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // Waits until the block is idle, then writes one register.
  task write_reg(logic idx, logic [20:0] data);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task set_filter(logic [20:0] size, logic [20:0] probes);
    write_reg(RegTableSize, size);
    write_reg(RegProbeCount, probes);
  endtask

  // One random transaction: mostly known keys so deletes and finds hit.
  task send_random();
    int        pick;
    bit [63:0] key;
    logic [1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 45) cmd = CmdAdd;
    else if (pick < 70) cmd = CmdFind;
    else if (pick < 95) cmd = CmdDel;
    else cmd = CmdUnused;
    if (key_pool.size() != 0 && $urandom_range(2) != 0)
      key = key_pool[$urandom_range(key_pool.size() - 1)];
    else
      key = {$urandom, $urandom};
    send(cmd, key[63:32], key[31:0]);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegTableSize;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    no_idle = 1'b0;
    stall_left = 0;
    cycles = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of the hashes, every command, absent deletes.
    send(CmdFind, 32'h0, 32'h0);
    send(CmdDel, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(CmdAdd, 32'h0, 32'h0);
    send(CmdAdd, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(CmdAdd, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(CmdFind, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(CmdFind, 32'h0, 32'h0);
    send(CmdUnused, 32'hFFFFFFFF, 32'h0);
    send(CmdDel, 32'h0, 32'h0);
    send(CmdDel, 32'h0, 32'h0);
    send(CmdDel, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(CmdFind, 32'hFFFFFFFF, 32'hFFFFFFFF);
    // Zero sizes are taken as one; oversize values saturate.
    set_filter(21'd0, 21'd0);
    send(CmdAdd, 32'h12345678, 32'h9ABCDEF0);
    send(CmdFind, 32'h0, 32'h1);
    set_filter(21'h1FFFFF, 21'd63);
    send(CmdAdd, 32'hA5A5A5A5, 32'h5A5A5A5A);
    send(CmdFind, 32'hA5A5A5A5, 32'h5A5A5A5A);
    send(CmdDel, 32'hA5A5A5A5, 32'h5A5A5A5A);
    // A repeated probe address drained to zero within one delete.
    set_filter(21'd1, 21'd1);
    send(CmdAdd, 32'h7, 32'h3);
    write_reg(RegProbeCount, 21'd3);
    send(CmdDel, 32'h7, 32'h3);
    send(CmdFind, 32'h7, 32'h3);

    // A single counter hit 32 times per add builds up a large count.
    write_reg(RegProbeCount, 21'd32);
    for (int n = 0; n < 20; n++) send(CmdAdd, $urandom, $urandom);
    send(CmdFind, 32'h0, 32'h0);
    send(CmdDel, 32'h1, 32'h2);
    send(CmdAdd, 32'h3, 32'h4);

    // Random phases over a spread of table sizes and probe counts.
    key_pool.delete();
    set_filter(21'd1048576, 21'd32);
    repeat (300) send_random();
    set_filter(21'd13, 21'd4);
    repeat (300) send_random();
    set_filter(21'd2, 21'd1);
    repeat (250) send_random();
    set_filter(21'd1000, 21'd8);
    repeat (300) send_random();
    set_filter(21'd64, 21'd3);
    repeat (300) send_random();
    set_filter(21'd1048575, 21'd6);
    repeat (200) send_random();
    no_idle = 1'b1;
    set_filter(21'd5, 21'd2);
    repeat (200) send_random();

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
    repeat (SettleCycles) @(posedge clk);
    $display("Ran %0d transactions (add, find, delete, unused code) over many filter", sent);
    $display("settings, including repeated probe addresses; %0d results checked.", sb.checked);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[counting_bloom_filter] OK");
    end else begin
      $display("[counting_bloom_filter] ERROR");
    end
    $finish;
  end
endmodule
